>>> hw/rtl/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

	// request codes on op
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_WR_CMD   = 3'd1;
	localparam logic [2:0] OP_WR_DATA  = 3'd2;
	localparam logic [2:0] OP_RD_STAT  = 3'd3;
	localparam logic [2:0] OP_RD_DATA  = 3'd4;
	localparam logic [2:0] OP_INIT     = 3'd5;
	localparam logic [2:0] OP_CLEAR    = 3'd6;

	// configuration register indexes
	localparam logic [3:0] CFG_STROBE     = 4'd0;
	localparam logic [3:0] CFG_INIT_LONG  = 4'd1;
	localparam logic [3:0] CFG_INIT_SHORT = 4'd2;
	localparam logic [3:0] CFG_CLEAR      = 4'd3;

	localparam logic [15:0] STROBE_RST     = 16'd37;
	localparam logic [15:0] INIT_LONG_RST  = 16'd4100;
	localparam logic [15:0] INIT_SHORT_RST = 16'd100;
	localparam logic [15:0] CLEAR_RST      = 16'd6200;

	// phase kinds of the sequence program
	localparam logic [3:0] K_END = 4'd0;
	localparam logic [3:0] K_WRC = 4'd1;
	localparam logic [3:0] K_WRH = 4'd2;
	localparam logic [3:0] K_WRL = 4'd3;
	localparam logic [3:0] K_RDH = 4'd4;
	localparam logic [3:0] K_RDL = 4'd5;
	localparam logic [3:0] K_LOW = 4'd6;
	localparam logic [3:0] K_WTL = 4'd7;
	localparam logic [3:0] K_WTS = 4'd8;
	localparam logic [3:0] K_WTC = 4'd9;

	// program entry points
	localparam logic [5:0] SEQ_WRITE = 6'd1;
	localparam logic [5:0] SEQ_READ  = 6'd6;
	localparam logic [5:0] SEQ_CLEAR = 6'd11;
	localparam logic [5:0] SEQ_INIT  = 6'd17;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] nib;
	} prog_t;

	typedef struct packed {
		logic [15:0] strobe_ticks;
		logic [15:0] init_long_ticks;
		logic [15:0] init_short_ticks;
		logic [15:0] clear_ticks;
	} cfg_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_not_write;
		logic       enable_pin;
		logic [3:0] data_out;
		logic       data_drive;
		logic       ready_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       rejected;
	} result_t;

	function automatic prog_t prog_entry(input logic [5:0] idx);
		prog_t e;
		unique case (idx)
			6'd1:  e = '{K_WRH, 4'd0};
			6'd2:  e = '{K_LOW, 4'd0};
			6'd3:  e = '{K_WRL, 4'd0};
			6'd4:  e = '{K_LOW, 4'd0};
			6'd6:  e = '{K_RDH, 4'd0};
			6'd7:  e = '{K_LOW, 4'd0};
			6'd8:  e = '{K_RDL, 4'd0};
			6'd9:  e = '{K_LOW, 4'd0};
			6'd11: e = '{K_WRC, 4'd0};
			6'd12: e = '{K_LOW, 4'd0};
			6'd13: e = '{K_WRC, 4'd1};
			6'd14: e = '{K_LOW, 4'd0};
			6'd15: e = '{K_WTC, 4'd0};
			6'd17: e = '{K_WRC, 4'd2};
			6'd18: e = '{K_LOW, 4'd0};
			6'd19: e = '{K_WTL, 4'd0};
			6'd20: e = '{K_WRC, 4'd2};
			6'd21: e = '{K_LOW, 4'd0};
			6'd22: e = '{K_WTS, 4'd0};
			6'd23: e = '{K_WRC, 4'd2};
			6'd24: e = '{K_LOW, 4'd0};
			6'd25: e = '{K_WRC, 4'd2};
			6'd26: e = '{K_LOW, 4'd0};
			6'd27: e = '{K_WRC, 4'd2};
			6'd28: e = '{K_LOW, 4'd0};
			6'd29: e = '{K_WRC, 4'd8};
			6'd30: e = '{K_LOW, 4'd0};
			6'd31: e = '{K_WRC, 4'd0};
			6'd32: e = '{K_LOW, 4'd0};
			6'd33: e = '{K_WRC, 4'd12};
			6'd34: e = '{K_LOW, 4'd0};
			6'd35: e = '{K_WRC, 4'd0};
			6'd36: e = '{K_LOW, 4'd0};
			6'd37: e = '{K_WRC, 4'd1};
			6'd38: e = '{K_LOW, 4'd0};
			6'd39: e = '{K_WTC, 4'd0};
			6'd40: e = '{K_WRC, 4'd0};
			6'd41: e = '{K_LOW, 4'd0};
			6'd42: e = '{K_WRC, 4'd6};
			6'd43: e = '{K_LOW, 4'd0};
			default: e = '{K_END, 4'd0};
		endcase
		return e;
	endfunction

endpackage

>>> hw/rtl/char_lcd_4bit_bus_sequencer_core.sv
`timescale 1ns / 1ps
// Character LCD sequencer for a 4-bit parallel bus.
// Request channel (req_valid/req_stall): one beat is one tick of the bus
// timing. op selects tick, write command, write data, read status, read data,
// init or clear; payload is the byte to write, bus_nibble the sampled pins.
// Result channel (res_valid/res_stall): exactly one beat per request beat,
// carrying the pin levels, ready_res, read_valid/read_byte and rejected.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0..3 selects strobe,
// long init, short init and clear pause lengths; other indexes are ignored.
// Write it only while no sequence is running.
// A result is registered in the output register, or in the skid register
// if the receiver stalls. Throughput is one beat per cycle while req_stall is
// low; the sequencer state updates once per accepted beat. The result side
// has an output register and a skid register, so req_stall rises only once
// both are full. Reset clears the sequencer to idle with all pins high and
// the data pins driven; pause lengths return to 37, 4100, 100 and 6200 ticks.

module char_lcd_4bit_bus_sequencer_core #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  payload,
	input  logic [3:0]  bus_nibble,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        reg_select,
	output logic        read_not_write,
	output logic        enable_pin,
	output logic [3:0]  data_out,
	output logic        data_drive,
	output logic        ready_res,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        rejected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lcdseq_pkg::cfg_t    cfg_q;
	lcdseq_pkg::result_t res_next, res_out;
	logic                accept;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_ticks     <= lcdseq_pkg::STROBE_RST;
			cfg_q.init_long_ticks  <= lcdseq_pkg::INIT_LONG_RST;
			cfg_q.init_short_ticks <= lcdseq_pkg::INIT_SHORT_RST;
			cfg_q.clear_ticks      <= lcdseq_pkg::CLEAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lcdseq_pkg::CFG_STROBE:     cfg_q.strobe_ticks     <= cfg_data;
				lcdseq_pkg::CFG_INIT_LONG:  cfg_q.init_long_ticks  <= cfg_data;
				lcdseq_pkg::CFG_INIT_SHORT: cfg_q.init_short_ticks <= cfg_data;
				lcdseq_pkg::CFG_CLEAR:      cfg_q.clear_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	lcdseq_ctrl #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.op        (op),
		.payload   (payload),
		.bus_nibble(bus_nibble),
		.cfg       (cfg_q),
		.res       (res_next)
	);

	lcdseq_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.din      (res_next),
		.full     (req_stall),
		.out_valid(res_valid),
		.out_stall(res_stall),
		.dout     (res_out)
	);

	assign reg_select     = res_out.reg_select;
	assign read_not_write = res_out.read_not_write;
	assign enable_pin     = res_out.enable_pin;
	assign data_out       = res_out.data_out;
	assign data_drive     = res_out.data_drive;
	assign ready_res      = res_out.ready_res;
	assign read_valid     = res_out.read_valid;
	assign read_byte      = res_out.read_byte;
	assign rejected       = res_out.rejected;

endmodule

>>> hw/rtl/lcdseq_ctrl.sv
`timescale 1ns / 1ps

module lcdseq_ctrl #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [2:0]          op,
	input  logic [7:0]          payload,
	input  logic [3:0]          bus_nibble,
	input  lcdseq_pkg::cfg_t    cfg,
	output lcdseq_pkg::result_t res
);

	localparam int          TW       = TICK_COUNT_WIDTH;
	localparam logic [32:0] CNT_MAX  = 33'((64'd1 << TW) - 64'd1);

	logic [5:0]    seq_step_q, seq_step_d;
	logic [TW-1:0] wait_q, wait_d;
	logic [7:0]    byte_hold_q, byte_hold_d;
	logic [7:0]    read_accum_q, read_accum_d;
	logic          rs_q, rs_d, rw_q, rw_d, en_q, en_d, drive_q, drive_d;
	logic [3:0]    data_q, data_d;

	logic              idle, is_req, rej, rd_valid, do_enter;
	logic [5:0]        start_step, next_step, enter_step;
	lcdseq_pkg::prog_t cur_e, nxt_e, ent_e;
	logic [15:0]       len, len_m1;
	logic [TW-1:0]     len_cnt;

	assign idle      = (seq_step_q == 6'd0);
	assign is_req    = (op >= lcdseq_pkg::OP_WR_CMD) && (op <= lcdseq_pkg::OP_CLEAR);
	assign next_step = seq_step_q + 6'd1;
	assign cur_e     = lcdseq_pkg::prog_entry(seq_step_q);
	assign nxt_e     = lcdseq_pkg::prog_entry(next_step);

	always_comb begin
		unique case (op) inside
			lcdseq_pkg::OP_WR_CMD, lcdseq_pkg::OP_WR_DATA: start_step = lcdseq_pkg::SEQ_WRITE;
			lcdseq_pkg::OP_RD_STAT, lcdseq_pkg::OP_RD_DATA: start_step = lcdseq_pkg::SEQ_READ;
			lcdseq_pkg::OP_INIT: start_step = lcdseq_pkg::SEQ_INIT;
			default: start_step = lcdseq_pkg::SEQ_CLEAR;
		endcase
	end

	assign enter_step = idle ? start_step : next_step;
	assign ent_e      = lcdseq_pkg::prog_entry(enter_step);

	// phase length: zero acts as one, then saturate to the counter width
	always_comb begin
		case (ent_e.kind)
			lcdseq_pkg::K_WTL: len = cfg.init_long_ticks;
			lcdseq_pkg::K_WTS: len = cfg.init_short_ticks;
			lcdseq_pkg::K_WTC: len = cfg.clear_ticks;
			default:           len = cfg.strobe_ticks;
		endcase
		len_m1 = (len == 16'd0) ? 16'd0 : len - 16'd1;
		if ({17'd0, len_m1} > CNT_MAX)
			len_cnt = '1;
		else
			len_cnt = TW'(len_m1);
	end

	always_comb begin
		seq_step_d   = seq_step_q;
		wait_d       = wait_q;
		byte_hold_d  = byte_hold_q;
		read_accum_d = read_accum_q;
		rs_d         = rs_q;
		rw_d         = rw_q;
		en_d         = en_q;
		drive_d      = drive_q;
		data_d       = data_q;
		rej          = 1'b0;
		rd_valid     = 1'b0;
		do_enter     = 1'b0;

		if (idle) begin
			if (is_req) begin
				seq_step_d = start_step;
				do_enter   = 1'b1;
				unique case (op) inside
					lcdseq_pkg::OP_WR_CMD, lcdseq_pkg::OP_WR_DATA: begin
						rw_d        = 1'b0;
						rs_d        = (op == lcdseq_pkg::OP_WR_DATA);
						byte_hold_d = payload;
					end
					lcdseq_pkg::OP_RD_STAT, lcdseq_pkg::OP_RD_DATA: begin
						rw_d    = 1'b1;
						rs_d    = (op == lcdseq_pkg::OP_RD_DATA);
						drive_d = 1'b0;
					end
					default: begin
						rw_d = 1'b0;
						rs_d = 1'b0;
					end
				endcase
			end
		end else begin
			rej = is_req;
			if (wait_q != '0) begin
				wait_d = wait_q - TW'(1);
			end else begin
				// sample the bus at the end of each enable-high read phase
				if (cur_e.kind == lcdseq_pkg::K_RDH) begin
					read_accum_d = {bus_nibble, 4'd0};
				end else if (cur_e.kind == lcdseq_pkg::K_RDL) begin
					read_accum_d = {read_accum_q[7:4], bus_nibble};
					rd_valid     = 1'b1;
				end
				if (nxt_e.kind == lcdseq_pkg::K_END) begin
					seq_step_d = 6'd0;
					en_d       = 1'b0;
					drive_d    = 1'b1;
					wait_d     = '0;
				end else begin
					seq_step_d = next_step;
					do_enter   = 1'b1;
				end
			end
		end

		if (do_enter) begin
			wait_d = len_cnt;
			case (ent_e.kind)
				lcdseq_pkg::K_WRC: begin
					data_d = ent_e.nib;
					en_d   = 1'b1;
				end
				lcdseq_pkg::K_WRH: begin
					data_d = byte_hold_d[7:4];
					en_d   = 1'b1;
				end
				lcdseq_pkg::K_WRL: begin
					data_d = byte_hold_d[3:0];
					en_d   = 1'b1;
				end
				lcdseq_pkg::K_RDH, lcdseq_pkg::K_RDL: en_d = 1'b1;
				default: en_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_step_q   <= 6'd0;
			wait_q       <= '0;
			byte_hold_q  <= 8'd0;
			read_accum_q <= 8'd0;
			rs_q         <= 1'b1;
			rw_q         <= 1'b1;
			en_q         <= 1'b1;
			data_q       <= 4'hF;
			drive_q      <= 1'b1;
		end else if (step) begin
			seq_step_q   <= seq_step_d;
			wait_q       <= wait_d;
			byte_hold_q  <= byte_hold_d;
			read_accum_q <= read_accum_d;
			rs_q         <= rs_d;
			rw_q         <= rw_d;
			en_q         <= en_d;
			data_q       <= data_d;
			drive_q      <= drive_d;
		end
	end

	always_comb begin
		res.reg_select     = rs_d;
		res.read_not_write = rw_d;
		res.enable_pin     = en_d;
		res.data_out       = data_d;
		res.data_drive     = drive_d;
		res.ready_res      = (seq_step_d == 6'd0);
		res.read_valid     = rd_valid;
		res.read_byte      = read_accum_d;
		res.rejected       = rej;
	end

endmodule

>>> hw/rtl/lcdseq_obuf.sv
`timescale 1ns / 1ps

module lcdseq_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lcdseq_pkg::result_t din,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output lcdseq_pkg::result_t dout
);

	logic                out_v_q, skid_v_q;
	lcdseq_pkg::result_t out_q, skid_q;
	logic                out_fire, load_out;

	assign out_fire  = out_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign dout      = out_q;
	assign load_out  = !out_v_q || out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (load_out) begin
				out_q <= din;
			end else begin
				skid_q <= din;
			end
		end
	end

endmodule

>>> hw/rtl/lcdseq_checker.sv
`timescale 1ns / 1ps

module lcdseq_checker (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic res_valid,
	input logic res_stall,
	input logic read_not_write,
	input logic data_drive,
	input logic ready_res,
	input logic read_valid
);

	// a completed read byte is only ever reported inside a read sequence
	a_read_valid_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && read_valid |-> read_not_write && !data_drive)
		else $error("read byte reported outside a read sequence");

	// pins are released only while reading
	a_release_means_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_drive |-> read_not_write)
		else $error("data pins released without read level on rw");

	// released pins mean the sequencer is still busy
	a_release_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_drive |-> !ready_res)
		else $error("sequencer idle with data pins released");

	// back-pressure on requests only follows a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_stall) |-> $past(res_valid && res_stall))
		else $error("request stall raised without a stalled result");

endmodule

bind char_lcd_4bit_bus_sequencer_core lcdseq_checker u_lcdseq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_stall     (req_stall),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.read_not_write(read_not_write),
	.data_drive    (data_drive),
	.ready_res     (ready_res),
	.read_valid    (read_valid)
);

>>> dv/lcdseq_pin_checker.sv
`timescale 1ns / 1ps

module lcdseq_pin_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  payload,
	input  logic [3:0]  bus_nibble,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        reg_select,
	input  logic        read_not_write,
	input  logic        enable_pin,
	input  logic [3:0]  data_out,
	input  logic        data_drive,
	input  logic        ready_res,
	input  logic        read_valid,
	input  logic [7:0]  read_byte,
	input  logic        rejected,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output logic        seq_idle
);

	typedef enum logic [3:0] {
		PH_END, PH_CMD, PH_HI, PH_LO, PH_RHI, PH_RLO, PH_GAP, PH_WLONG, PH_WSHORT, PH_WCLR
	} phase_kind_t;

	typedef struct packed {
		phase_kind_t kind;
		logic [3:0]  nib;
	} phase_t;

	localparam logic [5:0] ENTRY_WRITE = 6'd1;
	localparam logic [5:0] ENTRY_READ  = 6'd6;
	localparam logic [5:0] ENTRY_CLEAR = 6'd11;
	localparam logic [5:0] ENTRY_INIT  = 6'd17;

	logic [15:0] strobe_len, long_len, short_len, clr_len;
	logic [5:0]  cur_step;
	logic [15:0] ticks_left;
	logic [7:0]  wr_byte, rd_byte;
	logic        lvl_rs, lvl_rw, lvl_en, lvl_drv;
	logic [3:0]  lvl_data;

	lcdseq_pkg::result_t expected_pins[$];

	assign seq_idle = (cur_step == 6'd0);

	function automatic phase_t seq_phase(input logic [5:0] s);
		phase_t ph;
		ph.nib = 4'h0;
		case (s)
			6'd1: ph.kind = PH_HI;
			6'd3: ph.kind = PH_LO;
			6'd6: ph.kind = PH_RHI;
			6'd8: ph.kind = PH_RLO;
			6'd2, 6'd4, 6'd7, 6'd9, 6'd12, 6'd14, 6'd18, 6'd21, 6'd24, 6'd26, 6'd28,
			6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd41, 6'd43: ph.kind = PH_GAP;
			6'd19: ph.kind = PH_WLONG;
			6'd22: ph.kind = PH_WSHORT;
			6'd15, 6'd39: ph.kind = PH_WCLR;
			6'd11, 6'd31, 6'd35, 6'd40: ph.kind = PH_CMD;
			6'd13, 6'd37: begin
				ph.kind = PH_CMD;
				ph.nib = 4'h1;
			end
			// the init wake-up nibbles
			6'd17, 6'd20, 6'd23, 6'd25, 6'd27: begin
				ph.kind = PH_CMD;
				ph.nib = 4'h2;
			end
			6'd29: begin
				ph.kind = PH_CMD;
				ph.nib = 4'h8;
			end
			6'd33: begin
				ph.kind = PH_CMD;
				ph.nib = 4'hC;
			end
			6'd42: begin
				ph.kind = PH_CMD;
				ph.nib = 4'h6;
			end
			default: ph.kind = PH_END;
		endcase
		return ph;
	endfunction

	// a length of zero behaves as one tick
	function automatic logic [15:0] last_count(input logic [15:0] len);
		return (len == 16'd0) ? 16'd0 : len - 16'd1;
	endfunction

	task automatic start_phase();
		phase_t      ph;
		logic [15:0] len;
		ph = seq_phase(cur_step);
		len = strobe_len;
		case (ph.kind)
			PH_CMD: begin
				lvl_data = ph.nib;
				lvl_en = 1'b1;
			end
			PH_HI: begin
				lvl_data = wr_byte[7:4];
				lvl_en = 1'b1;
			end
			PH_LO: begin
				lvl_data = wr_byte[3:0];
				lvl_en = 1'b1;
			end
			PH_RHI, PH_RLO: lvl_en = 1'b1;
			PH_WLONG: begin
				lvl_en = 1'b0;
				len = long_len;
			end
			PH_WSHORT: begin
				lvl_en = 1'b0;
				len = short_len;
			end
			PH_WCLR: begin
				lvl_en = 1'b0;
				len = clr_len;
			end
			default: lvl_en = 1'b0;
		endcase
		ticks_left = last_count(len);
	endtask

	task automatic advance_sequencer(input logic [2:0] o, input logic [7:0] pl,
			input logic [3:0] bus, output lcdseq_pkg::result_t r);
		logic       is_req, got_read, rej;
		phase_t     ph;
		logic [5:0] nxt;
		is_req = (o >= lcdseq_pkg::OP_WR_CMD) && (o <= lcdseq_pkg::OP_CLEAR);
		got_read = 1'b0;
		rej = 1'b0;
		if (cur_step == 6'd0) begin
			if (is_req) begin
				case (o)
					lcdseq_pkg::OP_WR_CMD, lcdseq_pkg::OP_WR_DATA: begin
						lvl_rw = 1'b0;
						lvl_rs = (o == lcdseq_pkg::OP_WR_DATA);
						wr_byte = pl;
						cur_step = ENTRY_WRITE;
					end
					lcdseq_pkg::OP_RD_STAT, lcdseq_pkg::OP_RD_DATA: begin
						lvl_rw = 1'b1;
						lvl_rs = (o == lcdseq_pkg::OP_RD_DATA);
						lvl_drv = 1'b0;
						cur_step = ENTRY_READ;
					end
					lcdseq_pkg::OP_INIT: begin
						lvl_rw = 1'b0;
						lvl_rs = 1'b0;
						cur_step = ENTRY_INIT;
					end
					default: begin
						lvl_rw = 1'b0;
						lvl_rs = 1'b0;
						cur_step = ENTRY_CLEAR;
					end
				endcase
				start_phase();
			end
		end else begin
			rej = is_req;
			if (ticks_left != 16'd0) begin
				ticks_left = ticks_left - 16'd1;
			end else begin
				ph = seq_phase(cur_step);
				nxt = cur_step + 6'd1;
				// sample the bus as the enable high phase closes
				if (ph.kind == PH_RHI) begin
					rd_byte = {bus, 4'h0};
				end else if (ph.kind == PH_RLO) begin
					rd_byte[3:0] = bus;
					got_read = 1'b1;
				end
				if (seq_phase(nxt).kind == PH_END) begin
					cur_step = 6'd0;
					lvl_en = 1'b0;
					lvl_drv = 1'b1;
					ticks_left = 16'd0;
				end else begin
					cur_step = nxt;
					start_phase();
				end
			end
		end
		r = '{lvl_rs, lvl_rw, lvl_en, lvl_data, lvl_drv, cur_step == 6'd0, got_read,
			rd_byte, rej};
	endtask

	function automatic string pins_str(input lcdseq_pkg::result_t r);
		return $sformatf("rs %b rw %b en %b data %h drive %b ready %b rdv %b byte %h rej %b",
			r.reg_select, r.read_not_write, r.enable_pin, r.data_out, r.data_drive,
			r.ready_res, r.read_valid, r.read_byte, r.rejected);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcdseq_pkg::result_t want;
		lcdseq_pkg::result_t got;
		if (!arst_n) begin
			strobe_len = lcdseq_pkg::STROBE_RST;
			long_len = lcdseq_pkg::INIT_LONG_RST;
			short_len = lcdseq_pkg::INIT_SHORT_RST;
			clr_len = lcdseq_pkg::CLEAR_RST;
			cur_step = 6'd0;
			ticks_left = 16'd0;
			wr_byte = 8'h00;
			rd_byte = 8'h00;
			lvl_rs = 1'b1;
			lvl_rw = 1'b1;
			lvl_en = 1'b1;
			lvl_data = 4'hF;
			lvl_drv = 1'b1;
			expected_pins.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lcdseq_pkg::CFG_STROBE:     strobe_len = cfg_data;
					lcdseq_pkg::CFG_INIT_LONG:  long_len = cfg_data;
					lcdseq_pkg::CFG_INIT_SHORT: short_len = cfg_data;
					lcdseq_pkg::CFG_CLEAR:      clr_len = cfg_data;
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				got = '{reg_select, read_not_write, enable_pin, data_out, data_drive,
					ready_res, read_valid, read_byte, rejected};
				if (expected_pins.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with nothing expected: %s", $realtime,
							pins_str(got));
				end else begin
					want = expected_pins.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: pin mismatch\n  expected %s\n  actual   %s",
								$realtime, pins_str(want), pins_str(got));
					end
				end
			end
			if (req_valid && !req_stall) begin
				advance_sequencer(op, payload, bus_nibble, want);
				expected_pins.push_back(want);
			end
			pending = expected_pins.size();
		end
	end

endmodule

>>> dv/tb_char_lcd_4bit_bus_sequencer_core.sv
`timescale 1ns / 1ps

module tb_char_lcd_4bit_bus_sequencer_core;

	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int BUS_ANY = -1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  op;
	logic [7:0]  payload;
	logic [3:0]  bus_nibble;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        reg_select, read_not_write, enable_pin, data_drive;
	logic [3:0]  data_out;
	logic        ready_res, read_valid, rejected;
	logic [7:0]  read_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;

	bit   idle_on = 1'b0;
	int   stall_left = 0;
	int   cycles = 0;
	int   chk_errors;
	int   chk_pending;
	logic seq_idle;

	char_lcd_4bit_bus_sequencer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.payload       (payload),
		.bus_nibble    (bus_nibble),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.reg_select    (reg_select),
		.read_not_write(read_not_write),
		.enable_pin    (enable_pin),
		.data_out      (data_out),
		.data_drive    (data_drive),
		.ready_res     (ready_res),
		.read_valid    (read_valid),
		.read_byte     (read_byte),
		.rejected      (rejected),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	lcdseq_pin_checker pin_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.payload       (payload),
		.bus_nibble    (bus_nibble),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.reg_select    (reg_select),
		.read_not_write(read_not_write),
		.enable_pin    (enable_pin),
		.data_out      (data_out),
		.data_drive    (data_drive),
		.ready_res     (ready_res),
		.read_valid    (read_valid),
		.read_byte     (read_byte),
		.rejected      (rejected),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (chk_errors),
		.pending       (chk_pending),
		.seq_idle      (seq_idle)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_char_lcd_4bit_bus_sequencer_core NOT OK");
			$finish;
		end
	end

	// random receiver back-pressure in bursts, only while idle_on is set
	always @(posedge clk) begin
		if (!idle_on) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic push_request(input logic [2:0] o, input logic [7:0] pl,
			input logic [3:0] bus);
		cfg_valid <= 1'b0;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		payload <= pl;
		bus_nibble <= bus;
		do @(posedge clk); while (req_stall);
	endtask

	// drop valid and hold until every result beat is back
	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (chk_pending != 0);
		@(posedge clk);
	endtask

	task automatic tick_until_idle(input int chunk, input int bus_pick);
		do begin
			repeat (chunk)
				push_request(lcdseq_pkg::OP_TICK, 8'($urandom),
					(bus_pick < 0) ? 4'($urandom) : 4'(bus_pick));
			settle();
		end while (!seq_idle);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// mostly a request followed by a random run of ticks; short runs make
	// the next request land while busy
	task automatic random_traffic(input int beats);
		int         sent;
		int         run;
		logic [2:0] o;
		sent = 0;
		while (sent < beats) begin
			if ($urandom_range(0, 9) == 0) begin
				o = OP_SPARE;
			end else begin
				o = 3'($urandom_range(lcdseq_pkg::OP_WR_CMD, lcdseq_pkg::OP_CLEAR));
				if (o == lcdseq_pkg::OP_INIT && $urandom_range(0, 1) == 0)
					o = lcdseq_pkg::OP_WR_DATA;
			end
			push_request(o, 8'($urandom), 4'($urandom));
			run = $urandom_range(0, 24);
			repeat (run) push_request(lcdseq_pkg::OP_TICK, 8'($urandom), 4'($urandom));
			sent += run + 1;
		end
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		req_valid = 1'b0;
		op = lcdseq_pkg::OP_TICK;
		payload = 8'h00;
		bus_nibble = 4'h0;
		cfg_valid = 1'b0;
		cfg_index = lcdseq_pkg::CFG_STROBE;
		cfg_data = 16'h0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;

		// reset lengths
		push_request(lcdseq_pkg::OP_TICK, 8'h00, 4'h0);
		push_request(lcdseq_pkg::OP_WR_DATA, 8'hA5, 4'h0);
		tick_until_idle(16, BUS_ANY);

		// zero lengths act as one tick
		write_reg(lcdseq_pkg::CFG_STROBE, 16'd0);
		write_reg(lcdseq_pkg::CFG_INIT_LONG, 16'd1);
		write_reg(lcdseq_pkg::CFG_INIT_SHORT, 16'd0);
		write_reg(lcdseq_pkg::CFG_CLEAR, 16'd1);
		write_reg(4'($urandom_range(4, 15)), 16'($urandom));
		push_request(lcdseq_pkg::OP_WR_CMD, 8'h00, 4'h0);
		tick_until_idle(4, BUS_ANY);
		push_request(lcdseq_pkg::OP_WR_DATA, 8'hFF, 4'hF);
		tick_until_idle(4, BUS_ANY);
		push_request(lcdseq_pkg::OP_RD_STAT, 8'h00, 4'hF);
		tick_until_idle(4, 4'hF);
		push_request(lcdseq_pkg::OP_RD_DATA, 8'hFF, 4'h0);
		tick_until_idle(4, 4'h0);
		push_request(lcdseq_pkg::OP_RD_STAT, 8'h5A, 4'h9);
		tick_until_idle(4, BUS_ANY);
		push_request(lcdseq_pkg::OP_INIT, 8'h00, 4'h0);
		tick_until_idle(8, BUS_ANY);
		push_request(lcdseq_pkg::OP_CLEAR, 8'hFF, 4'hF);
		tick_until_idle(4, BUS_ANY);
		push_request(OP_SPARE, 8'h3C, 4'h6);
		// a write command starts a sequence; the requests while busy are turned away
		push_request(lcdseq_pkg::OP_WR_CMD, 8'hC3, 4'h0);
		push_request(lcdseq_pkg::OP_CLEAR, 8'h00, 4'h0);
		push_request(lcdseq_pkg::OP_RD_DATA, 8'h00, 4'hA);
		tick_until_idle(4, BUS_ANY);
		push_request(lcdseq_pkg::OP_INIT, 8'h00, 4'h0);
		push_request(lcdseq_pkg::OP_INIT, 8'h00, 4'h0);
		push_request(lcdseq_pkg::OP_WR_DATA, 8'h81, 4'h5);
		tick_until_idle(8, BUS_ANY);

		for (p = 0; p < 4; p++) begin
			write_reg(lcdseq_pkg::CFG_STROBE, 16'($urandom_range(1, 1 + 2 * p)));
			write_reg(lcdseq_pkg::CFG_INIT_LONG, 16'($urandom_range(1, 40)));
			write_reg(lcdseq_pkg::CFG_INIT_SHORT, 16'($urandom_range(1, 40)));
			write_reg(lcdseq_pkg::CFG_CLEAR, 16'($urandom_range(1, 40)));
			idle_on <= (p != 2);
			random_traffic(100);
			tick_until_idle(8, BUS_ANY);
		end

		// long pauses and strobes, no idling from here on
		idle_on <= 1'b0;
		write_reg(lcdseq_pkg::CFG_STROBE, 16'd1);
		write_reg(lcdseq_pkg::CFG_INIT_LONG, 16'd60);
		write_reg(lcdseq_pkg::CFG_INIT_SHORT, 16'd30);
		write_reg(lcdseq_pkg::CFG_CLEAR, 16'd40);
		push_request(lcdseq_pkg::OP_INIT, 8'h00, 4'h0);
		tick_until_idle(32, BUS_ANY);
		write_reg(lcdseq_pkg::CFG_STROBE, 16'd16);
		push_request(lcdseq_pkg::OP_RD_STAT, 8'h00, 4'h0);
		tick_until_idle(32, BUS_ANY);

		repeat (4) @(posedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("tb_char_lcd_4bit_bus_sequencer_core OK");
		else
			$display("tb_char_lcd_4bit_bus_sequencer_core NOT OK");
		$finish;
	end

endmodule
